// ----- hw/rtl/dna_pkg.sv -----
// dual number alu package: action and fault codes, stage payload types, saturation helper
// no dependencies; imported by every module of the dual number alu
`timescale 1ns / 1ps
`default_nettype none

package dna_pkg;

  // action codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_NORM = 3'd5,
    OP_SQRT = 3'd6,
    OP_INV  = 3'd7
  } dna_op_e;

  // fault codes carried in the output tuser
  typedef enum logic [1:0] {
    FAULT_OK   = 2'd0,
    FAULT_OVF  = 2'd1,
    FAULT_ZDIV = 2'd2,
    FAULT_SQRT = 2'd3
  } dna_fault_e;

  localparam int QW    = 32;  // width of one fixed point part
  localparam int DEN_W = 63;  // divisor and partial remainder width
  localparam int QB    = 33;  // quotient bits kept; larger quotients saturate
  localparam int SAT_W = 66;  // widest intermediate fed to saturation

  localparam logic [QW-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

  // one long division lane
  typedef struct packed {
    logic             neg;   // quotient sign
    logic             big;   // quotient at or above 2^QB
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    q;
    logic [QB-1:0]    nlo;   // low numerator bits still to bring down
  } dna_lane_t;

  // result parts that travel alongside the lanes
  typedef struct packed {
    logic [QW-1:0] res_real;
    logic [QW-1:0] res_dual;
    dna_fault_e    fault;
    logic          ovf;
    logic          div_r;     // real part comes from lane 0
    logic          div_d;     // dual part comes from lane 1
    logic          sqrt_fix;  // real part and lane 1 divisor come from the root
  } dna_res_t;

  typedef struct packed {
    logic [QW-1:0] val;
    logic          ovf;
  } dna_sat_t;

  // clamp a signed value to the 32-bit range
  function automatic dna_sat_t dna_sat(input logic signed [SAT_W-1:0] v);
    dna_sat_t r;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'(Q_MAX));
    lo = SAT_W'(signed'(Q_MIN));
    if (v > hi) begin
      r.val = Q_MAX;
      r.ovf = 1'b1;
    end else if (v < lo) begin
      r.val = Q_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[QW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dna_front.sv -----
// dual number alu front end: operand products, then direct results and division setup
// depends on dna_pkg
`timescale 1ns / 1ps
`default_nettype none

module dna_front #(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W     = 96,
  parameter int RAD_W     = 48
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   adv_i,
  input  wire                   valid_i,
  input  wire dna_pkg::dna_op_e action_i,
  input  wire signed [31:0]     x_real_i,
  input  wire signed [31:0]     x_dual_i,
  input  wire signed [31:0]     y_real_i,
  input  wire signed [31:0]     y_dual_i,
  output logic                  valid_o,
  output dna_pkg::dna_res_t     res_o,
  output dna_pkg::dna_lane_t    lane0_o,
  output dna_pkg::dna_lane_t    lane1_o,
  output logic [NUM_W-1:0]      num0_o,
  output logic [NUM_W-1:0]      num1_o,
  output logic [RAD_W-1:0]      rad_o
);
  import dna_pkg::*;

  logic               v1_q;
  dna_op_e            op1_q;
  logic signed [31:0] a_q, b_q, c_q, d_q;
  logic signed [63:0] p_ac_q, p_ad_q, p_bc_q, p_aa_q, p_cc_q;
  logic signed [63:0] p_ac_d, p_ad_d, p_bc_d, p_aa_d, p_cc_d;

  // stage 1: operand products ac, ad, bc, aa and cc
  assign p_ac_d = x_real_i * y_real_i;
  assign p_ad_d = x_real_i * y_dual_i;
  assign p_bc_d = x_dual_i * y_real_i;
  assign p_aa_d = x_real_i * x_real_i;
  assign p_cc_d = y_real_i * y_real_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op1_q  <= action_i;
      a_q    <= x_real_i;
      b_q    <= x_dual_i;
      c_q    <= y_real_i;
      d_q    <= y_dual_i;
      p_ac_q <= p_ac_d;
      p_ad_q <= p_ad_d;
      p_bc_q <= p_bc_d;
      p_aa_q <= p_aa_d;
      p_cc_q <= p_cc_d;
    end
  end

  // stage 2: direct results, special cases and lane setup
  dna_res_t           res_d;
  dna_lane_t          lane0_d, lane1_d;
  logic [NUM_W-1:0]   num0_d, num1_d;
  logic [RAD_W-1:0]   rad_d;
  logic [63:0]        m0, m1, wdiff, mdiff;
  logic [31:0]        abs_a, abs_b, abs_c;
  logic signed [SAT_W-1:0] s_rr, s_rd;
  dna_sat_t           sat_r, sat_d;
  logic               direct, sh2, b_pos;

  assign abs_a = a_q[31] ? 32'(-a_q) : a_q;
  assign abs_b = b_q[31] ? 32'(-b_q) : b_q;
  assign abs_c = c_q[31] ? 32'(-c_q) : c_q;
  assign wdiff = p_bc_q - p_ad_q;
  assign mdiff = wdiff[63] ? (~wdiff + 64'd1) : wdiff;
  assign b_pos = !b_q[31] && (b_q != '0);

  always_comb begin
    res_d   = '0;
    lane0_d = '0;
    lane1_d = '0;
    m0      = '0;
    m1      = '0;
    s_rr    = '0;
    s_rd    = '0;
    direct  = 1'b0;
    sh2     = 1'b0;
    unique case (op1_q)
      OP_ADD: begin
        direct = 1'b1;
        s_rr   = SAT_W'(a_q) + SAT_W'(c_q);
        s_rd   = SAT_W'(b_q) + SAT_W'(d_q);
      end
      OP_SUB: begin
        direct = 1'b1;
        s_rr   = SAT_W'(a_q) - SAT_W'(c_q);
        s_rd   = SAT_W'(b_q) - SAT_W'(d_q);
      end
      OP_MUL: begin
        direct = 1'b1;
        s_rr   = SAT_W'(p_ac_q >>> FRAC_BITS);
        s_rd   = (SAT_W'(p_ad_q) + SAT_W'(p_bc_q)) >>> FRAC_BITS;
      end
      OP_DIV: begin
        if (c_q == '0) begin
          res_d.res_real = a_q[31] ? Q_MIN : Q_MAX;
          res_d.res_dual = b_q[31] ? Q_MIN : Q_MAX;
          res_d.fault    = FAULT_ZDIV;
        end else begin
          res_d.div_r  = 1'b1;
          res_d.div_d  = 1'b1;
          m0           = {32'd0, abs_a};
          lane0_d.neg  = a_q[31] ^ c_q[31];
          lane0_d.den  = DEN_W'(abs_c);
          m1           = mdiff;
          lane1_d.neg  = wdiff[63];
          lane1_d.den  = p_cc_q[DEN_W-1:0];
        end
      end
      OP_CONJ: begin
        direct = 1'b1;
        s_rr   = SAT_W'(a_q);
        s_rd   = -SAT_W'(b_q);
      end
      OP_NORM: begin
        direct = 1'b1;
        s_rr   = a_q[31] ? -SAT_W'(a_q) : SAT_W'(a_q);
        s_rd   = '0;
      end
      OP_SQRT: begin
        if (a_q[31] || (a_q == '0)) begin
          res_d.res_real = '0;
          res_d.res_dual = b_q[31] ? Q_MIN : Q_MAX;
          res_d.fault    = FAULT_SQRT;
        end else begin
          res_d.div_d    = 1'b1;
          res_d.sqrt_fix = 1'b1;
          m1             = {32'd0, abs_b};
          lane1_d.neg    = b_q[31];
        end
      end
      OP_INV: begin
        if (a_q == '0) begin
          res_d.res_real = Q_MAX;
          res_d.res_dual = b_pos ? Q_MIN : Q_MAX;
          res_d.fault    = FAULT_ZDIV;
        end else begin
          res_d.div_r = 1'b1;
          res_d.div_d = 1'b1;
          sh2         = 1'b1;
          m0          = 64'd1;
          lane0_d.neg = a_q[31];
          lane0_d.den = DEN_W'(abs_a);
          m1          = {32'd0, abs_b};
          lane1_d.neg = b_pos;
          lane1_d.den = p_aa_q[DEN_W-1:0];
        end
      end
    endcase
    sat_r = dna_sat(s_rr);
    sat_d = dna_sat(s_rd);
    if (direct) begin
      res_d.res_real = sat_r.val;
      res_d.res_dual = sat_d.val;
      res_d.ovf      = sat_r.ovf | sat_d.ovf;
    end
    num0_d = sh2 ? (NUM_W'(m0) << (2 * FRAC_BITS)) : (NUM_W'(m0) << FRAC_BITS);
    num1_d = sh2 ? (NUM_W'(m1) << (2 * FRAC_BITS)) : (NUM_W'(m1) << FRAC_BITS);
    rad_d  = RAD_W'(a_q[30:0]) << FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o   <= res_d;
      lane0_o <= lane0_d;
      lane1_o <= lane1_d;
      num0_o  <= num0_d;
      num1_o  <= num1_d;
      rad_o   <= rad_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dna_sqrt_step.sv -----
// dual number alu square root stage: one root bit per stage, restoring form
// depends on dna_pkg for the shared coding style only
`timescale 1ns / 1ps
`default_nettype none

module dna_sqrt_step #(
  parameter int SQ_STEPS = 24,
  parameter int RAD_W    = 48,
  parameter int PW       = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    adv_i,
  input  wire                    valid_i,
  input  wire [RAD_W-1:0]        rad_i,
  input  wire [SQ_STEPS+1:0]     rem_i,
  input  wire [SQ_STEPS-1:0]     root_i,
  input  wire [PW-1:0]           pass_i,
  output logic                   valid_o,
  output logic [RAD_W-1:0]       rad_o,
  output logic [SQ_STEPS+1:0]    rem_o,
  output logic [SQ_STEPS-1:0]    root_o,
  output logic [PW-1:0]          pass_o
);
  import dna_pkg::*;

  logic [SQ_STEPS+1:0] rem_t, trial, rem_d;
  logic [SQ_STEPS-1:0] root_d;
  logic                ge;

  // bring down two radicand bits and try the next root bit
  assign rem_t  = {rem_i[SQ_STEPS-1:0], rad_i[RAD_W-1 -: 2]};
  assign trial  = {root_i, 2'b01};
  assign ge     = rem_t >= trial;
  assign rem_d  = ge ? (rem_t - trial) : rem_t;
  assign root_d = {root_i[SQ_STEPS-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rad_o  <= rad_i << 2;
      rem_o  <= rem_d;
      root_o <= root_d;
      pass_o <= pass_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dna_div_prep.sv -----
// dual number alu division setup: root fixup, quotient range check, first remainder
// depends on dna_pkg
`timescale 1ns / 1ps
`default_nettype none

module dna_div_prep #(
  parameter int NUM_W    = 96,
  parameter int SQ_STEPS = 24
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      adv_i,
  input  wire                      valid_i,
  input  wire dna_pkg::dna_res_t   res_i,
  input  wire dna_pkg::dna_lane_t  lane0_i,
  input  wire dna_pkg::dna_lane_t  lane1_i,
  input  wire [NUM_W-1:0]          num0_i,
  input  wire [NUM_W-1:0]          num1_i,
  input  wire [SQ_STEPS-1:0]       root_i,
  output logic                     valid_o,
  output dna_pkg::dna_res_t        res_o,
  output dna_pkg::dna_lane_t       lane0_o,
  output dna_pkg::dna_lane_t       lane1_o
);
  import dna_pkg::*;

  dna_res_t  res_d;
  dna_lane_t lane0_d, lane1_d;
  logic [NUM_W-QB-1:0] hi0, hi1;

  assign hi0 = num0_i[NUM_W-1:QB];
  assign hi1 = num1_i[NUM_W-1:QB];

  // quotient fits QB bits only while the upper numerator stays below the divisor
  always_comb begin
    res_d   = res_i;
    lane0_d = lane0_i;
    lane1_d = lane1_i;
    if (res_i.sqrt_fix) begin
      res_d.res_real = QW'(root_i);
      lane1_d.den    = DEN_W'({root_i, 1'b0});
    end
    lane0_d.big = hi0 >= lane0_d.den;
    lane0_d.rem = DEN_W'(hi0);
    lane0_d.nlo = num0_i[QB-1:0];
    lane0_d.q   = '0;
    lane1_d.big = hi1 >= lane1_d.den;
    lane1_d.rem = DEN_W'(hi1);
    lane1_d.nlo = num1_i[QB-1:0];
    lane1_d.q   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o   <= res_d;
      lane0_o <= lane0_d;
      lane1_o <= lane1_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dna_div_step.sv -----
// dual number alu division stage: one quotient bit for both lanes
// depends on dna_pkg
`timescale 1ns / 1ps
`default_nettype none

module dna_div_step #(
  parameter int BIT = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      adv_i,
  input  wire                      valid_i,
  input  wire dna_pkg::dna_res_t   res_i,
  input  wire dna_pkg::dna_lane_t  lane0_i,
  input  wire dna_pkg::dna_lane_t  lane1_i,
  output logic                     valid_o,
  output dna_pkg::dna_res_t        res_o,
  output dna_pkg::dna_lane_t       lane0_o,
  output dna_pkg::dna_lane_t       lane1_o
);
  import dna_pkg::*;

  // restoring step: shift in one numerator bit, subtract when it fits
  function automatic dna_lane_t lane_step(input dna_lane_t l);
    dna_lane_t r;
    logic [DEN_W:0] t;
    logic           ge;
    r  = l;
    t  = {l.rem, l.nlo[BIT]};
    ge = t >= {1'b0, l.den};
    r.rem    = ge ? DEN_W'(t - {1'b0, l.den}) : t[DEN_W-1:0];
    r.q[BIT] = ge;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o   <= res_i;
      lane0_o <= lane_step(lane0_i);
      lane1_o <= lane_step(lane1_i);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dna_back.sv -----
// dual number alu back end: quotient saturation, fault merge, output register
// depends on dna_pkg
`timescale 1ns / 1ps
`default_nettype none

module dna_back (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      valid_i,
  input  wire dna_pkg::dna_res_t   res_i,
  input  wire dna_pkg::dna_lane_t  lane0_i,
  input  wire dna_pkg::dna_lane_t  lane1_i,
  input  wire                      m_axis_tready_i,
  output logic                     adv_o,
  output logic                     m_axis_tvalid_o,
  output logic [63:0]              m_axis_tdata_o,
  output logic [1:0]               m_axis_tuser_o
);
  import dna_pkg::*;

  // signed quotient from magnitude and sign, clamped to 32 bits
  function automatic dna_sat_t lane_val(input dna_lane_t l);
    dna_sat_t   r;
    logic [QB-1:0] n;
    n = QB'(0) - l.q;
    if (l.neg) begin
      if (l.big || (l.q > {1'b0, Q_MIN})) begin
        r.val = Q_MIN;
        r.ovf = 1'b1;
      end else begin
        r.val = n[QW-1:0];
        r.ovf = 1'b0;
      end
    end else begin
      if (l.big || (l.q > {1'b0, Q_MAX})) begin
        r.val = Q_MAX;
        r.ovf = 1'b1;
      end else begin
        r.val = l.q[QW-1:0];
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction

  dna_sat_t      q0, q1;
  logic [QW-1:0] rr, rd;
  logic          ovf;
  dna_fault_e    fault;

  assign q0 = lane_val(lane0_i);
  assign q1 = lane_val(lane1_i);

  // pick lane results and merge faults
  always_comb begin
    rr  = res_i.div_r ? q0.val : res_i.res_real;
    rd  = res_i.div_d ? q1.val : res_i.res_dual;
    ovf = res_i.ovf | (res_i.div_r & q0.ovf) | (res_i.div_d & q1.ovf);
    if (res_i.fault != FAULT_OK) begin
      fault = res_i.fault;
    end else if (ovf) begin
      fault = FAULT_OVF;
    end else begin
      fault = FAULT_OK;
    end
  end

  // whole pipeline moves when the output word is empty or taken
  assign adv_o = !m_axis_tvalid_o || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (adv_o) begin
      m_axis_tvalid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      m_axis_tdata_o <= {rd, rr};
      m_axis_tuser_o <= fault;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dual_number_alu_unit.sv -----
// dual number alu top level: front end, square root pipeline, divider pipeline, back end
// depends on dna_pkg, dna_front, dna_sqrt_step, dna_div_prep, dna_div_step, dna_back
//
// Usage: each input word carries two dual numbers x and y in signed fixed point with
// FRAC_BITS fraction bits and an action code in tuser (add, sub, mul, div, conjugate,
// norm, sqrt, invert). Each word yields exactly one output word: real part in the low
// half of tdata, dual part in the high half, fault code in tuser.
// Stages in order: two front stages (products, setup), one square root stage per root
// bit, one setup stage, 33 divider stages of one quotient bit each and the output
// register. Every word takes all stages whatever its action.
// Throughput is one word per cycle. All stages advance together whenever the output
// register is empty or its word is taken; while a word waits at the output with tready
// low, the pipeline holds and s_axis_tready is low, nothing is lost or repeated.
// Reset clears all valid bits; the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module dual_number_alu_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [127:0] s_axis_tdata_i,   // x_real, x_dual, y_real, y_dual
  input  wire  [2:0]   s_axis_tuser_i,   // action
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,   // res_real, res_dual
  output logic [1:0]   m_axis_tuser_o    // fault
);
  import dna_pkg::*;

  localparam int NUM_W    = 64 + 2 * FRAC_BITS;
  localparam int SQ_STEPS = (32 + FRAC_BITS) / 2;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int PW       = $bits(dna_res_t) + 2 * $bits(dna_lane_t) + 2 * NUM_W;

  logic adv;
  assign s_axis_tready_o = adv;

  // front end
  logic             f_valid;
  dna_res_t         f_res;
  dna_lane_t        f_lane0, f_lane1;
  logic [NUM_W-1:0] f_num0, f_num1;
  logic [RAD_W-1:0] f_rad;

  dna_front #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W),
    .RAD_W     (RAD_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (s_axis_tvalid_i),
    .action_i (dna_op_e'(s_axis_tuser_i)),
    .x_real_i (s_axis_tdata_i[31:0]),
    .x_dual_i (s_axis_tdata_i[63:32]),
    .y_real_i (s_axis_tdata_i[95:64]),
    .y_dual_i (s_axis_tdata_i[127:96]),
    .valid_o  (f_valid),
    .res_o    (f_res),
    .lane0_o  (f_lane0),
    .lane1_o  (f_lane1),
    .num0_o   (f_num0),
    .num1_o   (f_num1),
    .rad_o    (f_rad)
  );

  // square root pipeline, everything else rides along
  logic                sq_valid [0:SQ_STEPS];
  logic [RAD_W-1:0]    sq_rad   [0:SQ_STEPS];
  logic [SQ_STEPS+1:0] sq_rem   [0:SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_root  [0:SQ_STEPS];
  logic [PW-1:0]       sq_pass  [0:SQ_STEPS];

  assign sq_valid[0] = f_valid;
  assign sq_rad[0]   = f_rad;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_pass[0]  = {f_res, f_lane0, f_lane1, f_num0, f_num1};

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    dna_sqrt_step #(
      .SQ_STEPS (SQ_STEPS),
      .RAD_W    (RAD_W),
      .PW       (PW)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (sq_valid[k]),
      .rad_i   (sq_rad[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .pass_i  (sq_pass[k]),
      .valid_o (sq_valid[k+1]),
      .rad_o   (sq_rad[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .pass_o  (sq_pass[k+1])
    );
  end

  dna_res_t         s_res;
  dna_lane_t        s_lane0, s_lane1;
  logic [NUM_W-1:0] s_num0, s_num1;

  assign {s_res, s_lane0, s_lane1, s_num0, s_num1} = sq_pass[SQ_STEPS];

  // divider pipeline
  logic      dv_valid [0:QB];
  dna_res_t  dv_res   [0:QB];
  dna_lane_t dv_lane0 [0:QB];
  dna_lane_t dv_lane1 [0:QB];

  dna_div_prep #(
    .NUM_W    (NUM_W),
    .SQ_STEPS (SQ_STEPS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sq_valid[SQ_STEPS]),
    .res_i   (s_res),
    .lane0_i (s_lane0),
    .lane1_i (s_lane1),
    .num0_i  (s_num0),
    .num1_i  (s_num1),
    .root_i  (sq_root[SQ_STEPS]),
    .valid_o (dv_valid[0]),
    .res_o   (dv_res[0]),
    .lane0_o (dv_lane0[0]),
    .lane1_o (dv_lane1[0])
  );

  for (genvar j = 0; j < QB; j++) begin : g_div
    dna_div_step #(
      .BIT (QB - 1 - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv_valid[j]),
      .res_i   (dv_res[j]),
      .lane0_i (dv_lane0[j]),
      .lane1_i (dv_lane1[j]),
      .valid_o (dv_valid[j+1]),
      .res_o   (dv_res[j+1]),
      .lane0_o (dv_lane0[j+1]),
      .lane1_o (dv_lane1[j+1])
    );
  end

  // back end and output register
  dna_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (dv_valid[QB]),
    .res_i           (dv_res[QB]),
    .lane0_i         (dv_lane0[QB]),
    .lane1_i         (dv_lane1[QB]),
    .m_axis_tready_i (m_axis_tready_i),
    .adv_o           (adv),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the dual number alu: directed and random words, an in-bench predictor,
// a scoreboard in arrival order, and random idling on both stream sides
// depends on dna_pkg and dual_number_alu_unit
`timescale 1ns / 1ps

module testbench;
  import dna_pkg::*;

  typedef struct {
    dna_op_e       op;
    logic [31:0]   xr, xd, yr, yd;
    bit            drain;   // wait for all results before sending this word
  } alu_word_t;

  typedef struct {
    logic [31:0] rr, rd;
    dna_fault_e  fault;
  } alu_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = OP_ADD;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  alu_word_t   pending_words[$];
  alu_result_t expected_results[$];
  alu_word_t   cur_word;
  int unsigned accepted_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned snd_idle, rcv_idle;

  dual_number_alu_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i), .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tuser_o(m_axis_tuser_o)
  );

  // clamp to the 32-bit signed range
  function automatic logic [31:0] clamp_s(input logic signed [127:0] v, inout bit ovf);
    if (v > 128'sh7fff_ffff) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (v < -128'sh8000_0000) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // sign and magnitude to 32-bit signed with saturation
  function automatic logic [31:0] clamp_m(input bit neg, input logic [127:0] m,
                                          inout bit ovf);
    logic signed [127:0] s;
    s = neg ? -$signed(m) : $signed(m);
    return clamp_s(s, ovf);
  endfunction

  // |num| * 2^sh / den truncated toward zero, sign from num and den_neg
  function automatic logic [31:0] fixed_quot(input logic signed [127:0] num,
      input bit den_neg, input int sh, input logic [127:0] den, inout bit ovf);
    logic [127:0] m;
    m = (num < 0) ? -num : num;
    return clamp_m((num < 0) != den_neg, (m << sh) / den, ovf);
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // expected result of one word
  function automatic alu_result_t dual_alu_predict(input alu_word_t w);
    alu_result_t o;
    logic signed [127:0] a, b, c, d;
    logic [63:0] root;
    bit ovf;
    a = $signed(w.xr);
    b = $signed(w.xd);
    c = $signed(w.yr);
    d = $signed(w.yd);
    ovf = 1'b0;
    o.fault = FAULT_OK;
    case (w.op)
      OP_ADD: begin
        o.rr = clamp_s(a + c, ovf);
        o.rd = clamp_s(b + d, ovf);
      end
      OP_SUB: begin
        o.rr = clamp_s(a - c, ovf);
        o.rd = clamp_s(b - d, ovf);
      end
      OP_MUL: begin
        o.rr = clamp_s((a * c) >>> 16, ovf);
        o.rd = clamp_s((a * d + b * c) >>> 16, ovf);
      end
      OP_DIV: begin
        if (c == 0) begin
          o.rr = (a >= 0) ? Q_MAX : Q_MIN;
          o.rd = (b >= 0) ? Q_MAX : Q_MIN;
          o.fault = FAULT_ZDIV;
        end else begin
          o.rr = fixed_quot(a, c < 0, 16, (c < 0) ? -c : c, ovf);
          o.rd = fixed_quot(c * b - a * d, 1'b0, 16, c * c, ovf);
        end
      end
      OP_CONJ: begin
        o.rr = w.xr;
        o.rd = clamp_s(-b, ovf);
      end
      OP_NORM: begin
        o.rr = clamp_s((a < 0) ? -a : a, ovf);
        o.rd = '0;
      end
      OP_SQRT: begin
        if (a <= 0) begin
          o.rr = '0;
          o.rd = (b >= 0) ? Q_MAX : Q_MIN;
          o.fault = FAULT_SQRT;
        end else begin
          root = floor_root(64'(a) << 16);
          o.rr = root[31:0];
          o.rd = fixed_quot(b, 1'b0, 16, 128'(root) * 2, ovf);
        end
      end
      default: begin
        if (a == 0) begin
          o.rr = Q_MAX;
          o.rd = (b > 0) ? Q_MIN : Q_MAX;
          o.fault = FAULT_ZDIV;
        end else begin
          o.rr = fixed_quot(128'sd1, a < 0, 32, (a < 0) ? -a : a, ovf);
          o.rd = fixed_quot(-b, 1'b0, 32, a * a, ovf);
        end
      end
    endcase
    if (o.fault == FAULT_OK && ovf) o.fault = FAULT_OVF;
    return o;
  endfunction

  // operand mix: full range, small magnitudes, and corner values
  function automatic logic [31:0] rand_operand();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4) return $urandom();
    if (k < 7) return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return Q_MAX;
      2: return Q_MIN;
      3: return 32'h0001_0000;
      4: return 32'hffff_0000;
      5: return 32'h1;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic add_word(input dna_op_e op, input logic [31:0] xr, xd, yr, yd,
                          input bit drain = 1'b0);
    alu_word_t w;
    w.op = op; w.xr = xr; w.xd = xd; w.yr = yr; w.yd = yd; w.drain = drain;
    pending_words.push_back(w);
  endtask

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // stimulus
  initial begin
    add_word(OP_ADD, Q_MAX, Q_MIN, 32'h1, 32'hffff_ffff);
    add_word(OP_ADD, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    add_word(OP_SUB, Q_MIN, Q_MAX, 32'h1, 32'hffff_ffff);
    add_word(OP_SUB, 32'h0003_0000, 32'h0001_8000, 32'h0001_0000, 32'hffff_0000);
    add_word(OP_MUL, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    add_word(OP_MUL, 32'hffff_8000, 32'h0000_0001, 32'h0002_0000, 32'hffff_ffff);
    add_word(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001);
    add_word(OP_DIV, 32'h0001_0000, 32'h1, 32'h0, 32'h5);
    add_word(OP_DIV, 32'hffff_0000, 32'hffff_ffff, 32'h0, 32'h0);
    add_word(OP_DIV, Q_MAX, Q_MIN, 32'h1, Q_MAX);
    add_word(OP_DIV, Q_MIN, Q_MAX, Q_MIN, Q_MIN);
    add_word(OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'hfffe_0000, 32'h0000_8000);
    add_word(OP_CONJ, Q_MIN, Q_MIN, 32'h0, 32'h0);
    add_word(OP_CONJ, 32'h1234_5678, Q_MAX, Q_MAX, Q_MAX);
    add_word(OP_NORM, Q_MIN, 32'h7, 32'h0, 32'h0);
    add_word(OP_NORM, 32'hffff_0000, Q_MAX, 32'h0, 32'h0);
    add_word(OP_SQRT, 32'h0, 32'h1, 32'h0, 32'h0);
    add_word(OP_SQRT, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
    add_word(OP_SQRT, Q_MAX, Q_MIN, 32'h0, 32'h0);
    add_word(OP_SQRT, 32'h1, Q_MAX, 32'h0, 32'h0);
    add_word(OP_INV, 32'h0, 32'h1, 32'h0, 32'h0);
    add_word(OP_INV, 32'h0, 32'h0, 32'h0, 32'h0);
    add_word(OP_INV, 32'h0, Q_MIN, 32'h0, 32'h0);
    add_word(OP_INV, 32'h1, Q_MIN, 32'h0, 32'h0);
    add_word(OP_INV, Q_MIN, Q_MAX, 32'h0, 32'h0);
    for (int i = 0; i < 1700; i++)
      add_word(dna_op_e'($urandom_range(0, 7)), rand_operand(), rand_operand(),
               rand_operand(), rand_operand(), i == 300 || i == 1000);
  end

  // reset and end of run
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_cnt == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // idle rates per phase
  always_comb begin
    if (accepted_cnt < 600) begin
      snd_idle = 7;
      rcv_idle = 61;
    end else if (accepted_cnt < 1200) begin
      snd_idle = 61;
      rcv_idle = 7;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
  end

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_results.push_back(dual_alu_predict(cur_word));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= snd_idle &&
            !(pending_words[0].drain && expected_results.size() != 0)) begin
          cur_word = pending_words.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {cur_word.yd, cur_word.yr, cur_word.xd, cur_word.xr};
          s_axis_tuser_i  <= cur_word.op;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and scoreboard
  always @(posedge clk_i) begin
    alu_result_t e;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word real %h dual %h fault %0d", $time,
                   m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tuser_o);
          error_cnt <= error_cnt + 1;
        end else begin
          e = expected_results.pop_front();
          if (m_axis_tdata_o[31:0] !== e.rr || m_axis_tdata_o[63:32] !== e.rd ||
              m_axis_tuser_o !== e.fault) begin
            $display("%0t: mismatch expected real %h dual %h fault %0d, got %h %h %0d",
                     $time, e.rr, e.rd, e.fault, m_axis_tdata_o[31:0],
                     m_axis_tdata_o[63:32], m_axis_tuser_o);
            error_cnt <= error_cnt + 1;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

endmodule
